// ===== rtl/crc64x_pkg.sv =====
// Package for the CRC-64/XZ engine: chunk geometry, polynomial and the
// 128-bit to 64-bit fold matrix, built at elaboration from the polynomial.
// No dependencies.
`default_nettype none

package crc64x_pkg;

	// Chunk geometry
	localparam int unsigned BYTES_PER_ITEM = 16;
	localparam int unsigned CRC_W          = 64;
	localparam int unsigned BLOCK_W        = 128;
	localparam int unsigned COUNT_W        = 5;

	// Reflected form of 0x42F0E1EBA9EA3693
	localparam logic [CRC_W-1:0] REFLECTED_POLY = 64'hC96C5795D7870F42;

	// Row k selects the block bits that feed remainder bit k
	typedef logic [BLOCK_W-1:0]           crc_row_t;
	typedef crc_row_t [CRC_W-1:0]         crc_mat_t;

	// Run each unit vector through a zero-state byte-serial CRC to get one column
	function automatic crc_mat_t crc_matrix();
		crc_mat_t         m;
		logic [BLOCK_W-1:0] msg;
		logic [CRC_W-1:0]   r;
		m = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			msg = crc_row_t'(1) << i;
			r = '0;
			for (int j = 0; j < BLOCK_W / 8; j++) begin
				r[7:0] = r[7:0] ^ msg[8*j +: 8];
				for (int b = 0; b < 8; b++) begin
					r = (r >> 1) ^ (r[0] ? REFLECTED_POLY : '0);
				end
			end
			for (int k = 0; k < CRC_W; k++) begin
				m[k][i] = r[k];
			end
		end
		return m;
	endfunction

	localparam crc_mat_t CRC_MAT = crc_matrix();

	// Zero-state CRC of a full 16-byte block: one parity tree per output bit
	function automatic logic [CRC_W-1:0] crc_apply(logic [BLOCK_W-1:0] blk);
		logic [CRC_W-1:0] res;
		for (int k = 0; k < CRC_W; k++) begin
			res[k] = ^(blk & CRC_MAT[k]);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/crc64x_fold.sv =====
// Folds up to 16 bytes of one chunk into a running CRC-64/XZ remainder.
// Depends on crc64x_pkg (fold matrix, geometry).
`default_nettype none

module crc64x_fold import crc64x_pkg::*; (
	input  wire logic [CRC_W-1:0]   rem,
	input  wire logic [63:0]        data_low,
	input  wire logic [63:0]        data_high,
	input  wire logic [COUNT_W-1:0] byte_count,
	output logic      [CRC_W-1:0]   next_rem
);

	logic [COUNT_W-1:0] n;
	logic [COUNT_W-1:0] lead;
	logic [BLOCK_W-1:0] blk;
	logic [CRC_W-1:0]   tail;

	// Clamp the count to the chunk size
	assign n = (byte_count > COUNT_W'(BYTES_PER_ITEM)) ? COUNT_W'(BYTES_PER_ITEM) : byte_count;
	assign lead = COUNT_W'(BLOCK_W / 8) - n;

	// Merge the remainder into the first bytes and right-align the valid bytes;
	// leading zero bytes do not disturb a zero-state CRC, bytes past the count drop off
	assign blk = ({{(BLOCK_W-CRC_W){1'b0}}, rem} ^ {data_high, data_low}) << {lead, 3'b000};

	// Remainder bytes not consumed by a short chunk just shift down
	assign tail = rem >> {n, 3'b000};

	assign next_rem = crc_apply(blk) ^ tail;

endmodule

`default_nettype wire

// ===== rtl/crc64_reflected_engine.sv =====
// CRC-64/XZ engine, top level: input stage, remainder register, result register.
// Depends on crc64x_pkg and crc64x_fold.
//
// Input channel s_axis carries one message chunk per transaction: up to 16
// bytes, lowest byte first, with the valid byte count and the seed in tdata.
// s_axis_tuser marks the first chunk of a message (remainder loaded from the
// inverted seed), s_axis_tlast the last one (a result is produced).
// Output channel m_axis carries one CRC value per message.
// Throughput: one chunk per cycle unless a held result blocks a last chunk,
// with the remainder fed back through the 16-byte fold logic.
// A last chunk is folded from the input stage into the result register.
// Reset clears the remainder to zero and empties both stages.
// When the receiver stalls, the result is held and further chunks keep flowing
// until a second last chunk reaches the fold stage; then s_axis_tready drops.
// A byte count above 16 is treated as 16.
`default_nettype none

module crc64_reflected_engine import crc64x_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// low to high: data_low[63:0], data_high[127:64], byte_count[132:128],
	// seed[196:133], zero fill[199:197]
	input  wire logic [199:0] s_axis_tdata,
	input  wire logic         s_axis_tlast,
	// first_chunk[0]
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// crc_value[63:0]
	output logic [63:0]       m_axis_tdata
);

	// Input stage
	logic               valid_s1;
	logic [63:0]        lo_s1;
	logic [63:0]        hi_s1;
	logic [COUNT_W-1:0] count_s1;
	logic [CRC_W-1:0]   seed_s1;
	logic               first_s1;
	logic               last_s1;

	logic [CRC_W-1:0]   rem_q;
	logic               out_valid_q;
	logic [CRC_W-1:0]   crc_q;

	logic               advance;
	logic [CRC_W-1:0]   base_rem;
	logic [CRC_W-1:0]   next_rem;

	// Stage moves on unless it holds a result and the output slot stays full
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Capture the chunk
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			lo_s1    <= s_axis_tdata[63:0];
			hi_s1    <= s_axis_tdata[127:64];
			count_s1 <= s_axis_tdata[132:128];
			seed_s1  <= s_axis_tdata[196:133];
			first_s1 <= s_axis_tuser;
			last_s1  <= s_axis_tlast;
		end
	end

	// Start from the inverted seed on a first chunk
	assign base_rem = first_s1 ? ~seed_s1 : rem_q;

	crc64x_fold u_fold (
		.rem        (base_rem),
		.data_low   (lo_s1),
		.data_high  (hi_s1),
		.byte_count (count_s1),
		.next_rem   (next_rem)
	);

	// Advance the running remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (advance) begin
			rem_q <= next_rem;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			crc_q <= ~next_rem;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = crc_q;

`ifndef SYNTHESIS
	// A last chunk leaving the fold stage always lands in the result register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> m_axis_tvalid && (m_axis_tdata == ~$past(next_rem)))
		else $error("result not loaded from last chunk");

	// Input stalls come only from a held result blocking a pending last chunk
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && last_s1 && m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// The remainder only changes when a chunk is folded
	a_rem_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(rem_q))
		else $error("remainder changed without a chunk");
`endif

endmodule

`default_nettype wire
